// ----- src/svx_pkg.sv -----
// Shared opcodes, fault codes, read-select codes and item types for the stack machine.
`timescale 1ns / 1ps

package svx_pkg;

  // Instruction codes.
  localparam logic [5:0] OP_LEA  = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_CALL = 6'd3;
  localparam logic [5:0] OP_JZ   = 6'd4;
  localparam logic [5:0] OP_JNZ  = 6'd5;
  localparam logic [5:0] OP_ENT  = 6'd6;
  localparam logic [5:0] OP_ADJ  = 6'd7;
  localparam logic [5:0] OP_LEV  = 6'd8;
  localparam logic [5:0] OP_LI   = 6'd9;
  localparam logic [5:0] OP_LC   = 6'd10;
  localparam logic [5:0] OP_SI   = 6'd11;
  localparam logic [5:0] OP_SC   = 6'd12;
  localparam logic [5:0] OP_PUSH = 6'd13;
  localparam logic [5:0] OP_OR   = 6'd14;
  localparam logic [5:0] OP_XOR  = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_EQ   = 6'd17;
  localparam logic [5:0] OP_NE   = 6'd18;
  localparam logic [5:0] OP_LT   = 6'd19;
  localparam logic [5:0] OP_GT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GE   = 6'd22;
  localparam logic [5:0] OP_SHL  = 6'd23;
  localparam logic [5:0] OP_SHR  = 6'd24;
  localparam logic [5:0] OP_ADD  = 6'd25;
  localparam logic [5:0] OP_SUB  = 6'd26;
  localparam logic [5:0] OP_MUL  = 6'd27;
  localparam logic [5:0] OP_DIV  = 6'd28;
  localparam logic [5:0] OP_MOD  = 6'd29;
  localparam logic [5:0] OP_EXIT = 6'd37;

  // Fault codes.
  localparam logic [1:0] FLT_OK    = 2'd0;
  localparam logic [1:0] FLT_UNSUP = 2'd1;
  localparam logic [1:0] FLT_DIV0  = 2'd2;
  localparam logic [1:0] FLT_ADDR  = 2'd3;

  // Which pointer addresses the first memory read of an instruction.
  localparam logic [1:0] RS_NONE = 2'd0;
  localparam logic [1:0] RS_SP   = 2'd1;
  localparam logic [1:0] RS_BP   = 2'd2;
  localparam logic [1:0] RS_AX   = 2'd3;

  localparam logic [15:0] STACK_TOP_RST = 16'h8000;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [63:0] operand;
    logic [1:0]  rsel;
  } svx_item_t;

  typedef struct packed {
    logic [63:0] acc_value;
    logic [15:0] next_pc;
    logic        halted;
    logic [63:0] exit_value;
    logic [1:0]  fault;
  } svx_res_t;

  // Classifies an opcode by the first memory word it needs.
  function automatic logic [1:0] svx_rsel(input logic [5:0] op);
    logic [1:0] rs;
    unique case (op) inside
      OP_LEV:                       rs = RS_BP;
      OP_LI, OP_LC:                 rs = RS_AX;
      OP_SI, OP_SC, [OP_OR:OP_MOD],
      OP_EXIT:                      rs = RS_SP;
      default:                      rs = RS_NONE;
    endcase
    return rs;
  endfunction

endpackage

// ----- src/svx_ifs.sv -----
// Valid/ready channel interfaces for instruction items and result items.
`timescale 1ns / 1ps

interface svx_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         opcode;
  logic signed [63:0] operand;
  modport source (output valid, opcode, operand, input ready);
  modport sink   (input valid, opcode, operand, output ready);
endinterface

interface svx_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] acc_value;
  logic [15:0]        next_pc;
  logic               halted;
  logic signed [63:0] exit_value;
  logic [1:0]         fault;
  modport source (output valid, acc_value, next_pc, halted, exit_value, fault, input ready);
  modport sink   (input valid, acc_value, next_pc, halted, exit_value, fault, output ready);
endinterface

// ----- src/svx_front.sv -----
// Front end: accepts instruction items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module svx_front
  import svx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  svx_in_if.sink      in_ch,
  input  logic        busy,
  output svx_item_t   q_item,
  output logic        q_valid,
  input  logic        q_pop
);

  svx_item_t  q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;

  // No transfer while the memory is being cleared or the queue is full.
  assign in_ch.ready = (cnt_r != 2'd2) && !busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = q_r[rp_r];

  // Queue storage with its classification.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{opcode: in_ch.opcode, operand: in_ch.operand,
                     rsel: svx_rsel(in_ch.opcode)};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- src/svx_div.sv -----
// Iterative signed divider, one quotient bit per cycle, giving quotient or remainder.
`timescale 1ns / 1ps

module svx_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  logic        want_rem,
  output logic        done,
  output logic [63:0] result
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [63:0] rem_r;
  logic [63:0] dvs_r;
  logic        na_r;
  logic        nq_r;
  logic        rem_sel_r;
  logic [63:0] res_r;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        qbit;
  logic [63:0] rem_new;
  logic [63:0] quo_new;

  assign done   = done_r;
  assign result = res_r;

  // One restoring step.
  always_comb begin
    shifted = {rem_r, quo_r[63]};
    diff    = shifted - {1'b0, dvs_r};
    qbit    = !diff[64];
    rem_new = qbit ? diff[63:0] : shifted[63:0];
    quo_new = {quo_r[62:0], qbit};
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend[63] ? (64'd0 - dividend) : dividend;
      dvs_r     <= divisor[63] ? (64'd0 - divisor) : divisor;
      rem_r     <= 64'd0;
      na_r      <= dividend[63];
      nq_r      <= dividend[63] ^ divisor[63];
      rem_sel_r <= want_rem;
    end else if (busy_r) begin
      quo_r <= quo_new;
      rem_r <= rem_new;
      if (cnt_r == 6'd0) begin
        if (rem_sel_r) res_r <= na_r ? (64'd0 - rem_new) : rem_new;
        else           res_r <= nq_r ? (64'd0 - quo_new) : quo_new;
      end
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd63;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// ----- src/svx_back.sv -----
// Back end: executes queued instructions against the registers and the word memory.
`timescale 1ns / 1ps

module svx_back
  import svx_pkg::*;
#(
  parameter int MEM_WORDS = 4096,
  parameter int PC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  svx_item_t   q_item,
  input  logic        q_valid,
  output logic        q_pop,
  output logic        busy,
  svx_out_if.source   out_ch
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_A    = 3'd2;
  localparam logic [2:0] S_B    = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  logic [63:0] mem [MEM_WORDS];

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [5:0]         op_r, op_nxt;
  logic [63:0]        opd_r, opd_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  logic [15:0]        sp_r, sp_nxt;
  logic [15:0]        bp_r, bp_nxt;
  logic               halt_r, halt_nxt;
  logic [63:0]        exitw_r, exitw_nxt;
  logic [63:0]        u_r, u_nxt;
  logic [63:0]        mul_r, mul_nxt;
  logic [1:0]         mcnt_r, mcnt_nxt;
  svx_res_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        rdata_r;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  logic               fin;
  logic [1:0]         flt;
  logic [63:0]        ax;
  logic [PC_BITS-1:0] pc;
  logic [15:0]        sp;
  logic [15:0]        bp;
  logic               hlt;
  logic [63:0]        exw;
  logic               wr;
  logic [AW-1:0]      wa;
  logic [63:0]        wd;

  logic               out_free;
  logic [PC_BITS-1:0] pc1, pc2, tgt;
  logic [15:0]        sp_dn, sp_up, bp8;
  logic [63:0]        woff;
  logic [7:0]         lc_byte;
  logic [5:0]         sc_sh;
  logic [31:0]        m_a, m_b;
  logic [63:0]        m_prod;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_res;

  function automatic logic word_ok(input logic [63:0] a);
    return (a[2:0] == 3'd0) && (a[63:3] < 61'(MEM_WORDS));
  endfunction

  function automatic logic byte_ok(input logic [63:0] a);
    return a[63:3] < 61'(MEM_WORDS);
  endfunction

  function automatic logic [AW-1:0] widx(input logic [63:0] a);
    return a[3 +: AW];
  endfunction

  function automatic logic [63:0] sext8(input logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

  // Combinational operations on the popped stack word t and the accumulator a.
  function automatic logic [63:0] alu(input logic [5:0] op, input logic [63:0] t,
                                      input logic [63:0] a);
    logic [63:0] r;
    logic        big;
    big = |a[63:6];
    unique case (op)
      OP_OR:   r = t | a;
      OP_XOR:  r = t ^ a;
      OP_AND:  r = t & a;
      OP_EQ:   r = 64'(t == a);
      OP_NE:   r = 64'(t != a);
      OP_LT:   r = 64'($signed(t) < $signed(a));
      OP_GT:   r = 64'($signed(a) < $signed(t));
      OP_LE:   r = 64'(!($signed(a) < $signed(t)));
      OP_GE:   r = 64'(!($signed(t) < $signed(a)));
      OP_SHL:  r = big ? 64'd0 : (t << a[5:0]);
      OP_SHR:  r = big ? {64{t[63]}} : 64'($signed(t) >>> a[5:0]);
      OP_ADD:  r = t + a;
      OP_SUB:  r = t - a;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  svx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rdata_r),
    .divisor  (acc_r),
    .want_rem (op_r == OP_MOD),
    .done     (div_done),
    .result   (div_res)
  );

  assign busy     = (state_r == S_CLR);
  assign out_free = !out_valid_r || out_ch.ready;

  assign pc1     = pc_r + PC_BITS'(1);
  assign pc2     = pc_r + PC_BITS'(2);
  assign tgt     = opd_r[PC_BITS-1:0];
  assign sp_dn   = sp_r - 16'd8;
  assign sp_up   = sp_r + 16'd8;
  assign bp8     = bp_r + 16'd8;
  assign woff    = {opd_r[60:0], 3'b000};
  assign lc_byte = 8'(rdata_r >> {acc_r[2:0], 3'b000});
  assign sc_sh   = {u_r[2:0], 3'b000};

  // One 32x32 partial product of the multiply per cycle.
  always_comb begin
    unique case (mcnt_r)
      2'd0:    begin m_a = rdata_r[31:0];  m_b = acc_r[31:0];  end
      2'd1:    begin m_a = rdata_r[31:0];  m_b = acc_r[63:32]; end
      default: begin m_a = rdata_r[63:32]; m_b = acc_r[31:0];  end
    endcase
    m_prod = m_a * m_b;
  end

  // Sequencer and instruction execution.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    opd_nxt       = opd_r;
    acc_nxt       = acc_r;
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    bp_nxt        = bp_r;
    halt_nxt      = halt_r;
    exitw_nxt     = exitw_r;
    u_nxt         = u_r;
    mul_nxt       = mul_r;
    mcnt_nxt      = mcnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = 64'd0;
    div_start     = 1'b0;
    fin           = 1'b0;
    flt           = FLT_OK;
    ax            = acc_r;
    pc            = pc_r;
    sp            = sp_r;
    bp            = bp_r;
    hlt           = halt_r;
    exw           = exitw_r;
    wr            = 1'b0;
    wa            = '0;
    wd            = 64'd0;

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == AW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
        else                             clr_nxt   = clr_r + AW'(1);
      end

      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_item.opcode;
          opd_nxt   = q_item.operand;
          state_nxt = S_A;
          unique case (q_item.rsel)
            RS_SP:   begin mem_re = 1'b1; mem_raddr = widx(64'(sp_r)); end
            RS_BP:   begin mem_re = 1'b1; mem_raddr = widx(64'(bp_r)); end
            RS_AX:   begin mem_re = 1'b1; mem_raddr = widx(acc_r);     end
            default: mem_re = 1'b0;
          endcase
        end
      end

      S_A: begin
        fin = 1'b1;
        if (!halt_r) begin
          unique case (op_r) inside
            OP_LEA: begin ax = 64'(bp_r) + woff; pc = pc2; end
            OP_IMM: begin ax = opd_r; pc = pc2; end
            OP_JMP: pc = tgt;
            OP_CALL: begin
              if (!word_ok(64'(sp_dn))) flt = FLT_ADDR;
              else begin
                wr = 1'b1; wa = widx(64'(sp_dn)); wd = 64'(pc2);
                sp = sp_dn; pc = tgt;
              end
            end
            OP_JZ:  pc = (acc_r == 64'd0) ? tgt : pc2;
            OP_JNZ: pc = (acc_r != 64'd0) ? tgt : pc2;
            OP_ENT: begin
              if (!word_ok(64'(sp_dn))) flt = FLT_ADDR;
              else begin
                wr = 1'b1; wa = widx(64'(sp_dn)); wd = 64'(bp_r);
                bp = sp_dn; sp = sp_dn - woff[15:0]; pc = pc2;
              end
            end
            OP_ADJ: begin sp = sp_r + woff[15:0]; pc = pc2; end
            OP_LEV: begin
              if (!word_ok(64'(bp_r)) || !word_ok(64'(bp8))) flt = FLT_ADDR;
              else begin
                fin = 1'b0; u_nxt = rdata_r;
                mem_re = 1'b1; mem_raddr = widx(64'(bp8)); state_nxt = S_B;
              end
            end
            OP_LI: begin
              if (!word_ok(acc_r)) flt = FLT_ADDR;
              else begin ax = rdata_r; pc = pc1; end
            end
            OP_LC: begin
              if (!byte_ok(acc_r)) flt = FLT_ADDR;
              else begin ax = sext8(lc_byte); pc = pc1; end
            end
            OP_SI: begin
              if (!word_ok(64'(sp_r)) || !word_ok(rdata_r)) flt = FLT_ADDR;
              else begin
                wr = 1'b1; wa = widx(rdata_r); wd = acc_r;
                sp = sp_up; pc = pc1;
              end
            end
            OP_SC: begin
              if (!word_ok(64'(sp_r)) || !byte_ok(rdata_r)) flt = FLT_ADDR;
              else begin
                fin = 1'b0; u_nxt = rdata_r;
                mem_re = 1'b1; mem_raddr = widx(rdata_r); state_nxt = S_B;
              end
            end
            OP_PUSH: begin
              if (!word_ok(64'(sp_dn))) flt = FLT_ADDR;
              else begin
                wr = 1'b1; wa = widx(64'(sp_dn)); wd = acc_r;
                sp = sp_dn; pc = pc1;
              end
            end
            OP_EXIT: begin
              if (!word_ok(64'(sp_r))) flt = FLT_ADDR;
              else begin exw = rdata_r; hlt = 1'b1; pc = pc1; end
            end
            [OP_OR:OP_MOD]: begin
              if (!word_ok(64'(sp_r))) flt = FLT_ADDR;
              else if ((op_r == OP_DIV || op_r == OP_MOD) && acc_r == 64'd0) flt = FLT_DIV0;
              else if (op_r == OP_MUL) begin
                fin = 1'b0; mul_nxt = 64'd0; mcnt_nxt = 2'd0; state_nxt = S_MUL;
              end else if (op_r == OP_DIV || op_r == OP_MOD) begin
                fin = 1'b0; div_start = 1'b1; state_nxt = S_DIV;
              end else begin
                ax = alu(op_r, rdata_r, acc_r); sp = sp_up; pc = pc1;
              end
            end
            default: flt = FLT_UNSUP;
          endcase
        end
      end

      S_B: begin
        fin = 1'b1;
        if (op_r == OP_LEV) begin
          pc = rdata_r[PC_BITS-1:0]; sp = bp8 + 16'd8; bp = u_r[15:0];
        end else begin
          wr = 1'b1; wa = widx(u_r);
          wd = (rdata_r & ~(64'hFF << sc_sh)) | (64'(acc_r[7:0]) << sc_sh);
          ax = sext8(acc_r[7:0]); sp = sp_up; pc = pc1;
        end
      end

      S_MUL: begin
        if (mcnt_r == 2'd3) begin
          fin = 1'b1; ax = mul_r; sp = sp_up; pc = pc1;
        end else begin
          mul_nxt  = mul_r + ((mcnt_r == 2'd0) ? m_prod : {m_prod[31:0], 32'd0});
          mcnt_nxt = mcnt_r + 2'd1;
        end
      end

      S_DIV: begin
        if (div_done) begin
          fin = 1'b1; ax = div_res; sp = sp_up; pc = pc1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Retire the instruction once the result register is free.
    if (fin && out_free) begin
      state_nxt             = S_IDLE;
      out_valid_nxt         = 1'b1;
      out_nxt.fault         = flt;
      out_nxt.acc_value     = (flt == FLT_OK) ? ax : acc_r;
      out_nxt.next_pc       = 16'((flt == FLT_OK) ? pc : pc_r);
      out_nxt.halted        = (flt == FLT_OK) ? hlt : halt_r;
      out_nxt.exit_value    = out_nxt.halted ? ((flt == FLT_OK) ? exw : exitw_r) : 64'd0;
      if (flt == FLT_OK) begin
        acc_nxt   = ax;
        pc_nxt    = pc;
        sp_nxt    = sp;
        bp_nxt    = bp;
        halt_nxt  = hlt;
        exitw_nxt = exw;
        mem_we    = wr;
        mem_waddr = wa;
        mem_wdata = wd;
      end
    end

    // A configuration write reloads both pointers.
    if (cfg_we) begin
      sp_nxt = cfg_wdata;
      bp_nxt = cfg_wdata;
    end
  end

  // Word memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    opd_r <= opd_nxt;
    u_r   <= u_nxt;
    mul_r <= mul_nxt;
    out_r <= out_nxt;
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      mcnt_r      <= 2'd0;
      acc_r       <= 64'd0;
      pc_r        <= '0;
      sp_r        <= STACK_TOP_RST;
      bp_r        <= STACK_TOP_RST;
      halt_r      <= 1'b0;
      exitw_r     <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      mcnt_r      <= mcnt_nxt;
      acc_r       <= acc_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      bp_r        <= bp_nxt;
      halt_r      <= halt_nxt;
      exitw_r     <= exitw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.acc_value  = out_r.acc_value;
  assign out_ch.next_pc    = out_r.next_pc;
  assign out_ch.halted     = out_r.halted;
  assign out_ch.exit_value = out_r.exit_value;
  assign out_ch.fault      = out_r.fault;

endmodule

// ----- src/stack_vm_executor.sv -----
// Top level of the accumulator-plus-stack instruction executor.
`timescale 1ns / 1ps

// Executes one instruction per transfer on in_ch and gives one result per instruction on
// out_ch. After reset the word memory is cleared one word a cycle, and no instruction is
// taken until the clear is done; cfg_we is honoured throughout. A two-entry queue sits
// between the front end and the executing back end. Most instructions pass through
// S_IDLE (a stack memory read) and S_A (execute and write back); LEV and SC add S_B for
// their second memory read, MUL adds S_MUL for three 32x32 partial products and a retire
// step, and DIV and MOD wait in S_DIV on the bit-serial divider. A result waiting in the
// output register only holds up the back end once the next one is finished.
module stack_vm_executor
  import svx_pkg::*;
#(
  parameter int MEM_WORDS = 4096,
  parameter int PC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  svx_in_if.sink      in_ch,
  svx_out_if.source   out_ch
);

  svx_item_t q_item;
  logic      q_valid;
  logic      q_pop;
  logic      busy;

  svx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .busy    (busy),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  svx_back #(
    .MEM_WORDS (MEM_WORDS),
    .PC_BITS   (PC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_ch    (out_ch)
  );

endmodule
